// File: sv/sts_pkg.sv
package sts_pkg;

	localparam int unsigned MODE_W              = 2;
	localparam int unsigned IDX_W               = 10;
	localparam int unsigned WORD_W              = 32;
	localparam int unsigned POS_W               = 10;
	localparam int unsigned CFG_LEN_W           = 11;
	localparam int unsigned DEFAULT_TABLE_DEPTH = 1024;

	typedef enum logic [MODE_W-1:0] {
		MODE_STORE  = 2'd0,
		MODE_BINARY = 2'd1,
		MODE_LINEAR = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BIN,
		ST_LIN,
		ST_DONE
	} state_t;

endpackage

// File: sv/sts_if.sv
interface sts_in_if import sts_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [MODE_W-1:0]        mode;
	logic [IDX_W-1:0]         entry_index;
	logic signed [WORD_W-1:0] word_value;

	modport source (output valid, output mode, output entry_index, output word_value,
		input ready);
	modport sink (input valid, input mode, input entry_index, input word_value,
		output ready);
endinterface

interface sts_out_if import sts_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             found;
	logic [POS_W-1:0] position;

	modport source (output valid, output found, output position, input ready);
	modport sink (input valid, input found, input position, output ready);
endinterface

// File: sv/sts_table.sv
module sts_table import sts_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic                            clk,
	input  logic                            wr_en,
	input  logic [$clog2(TABLE_DEPTH)-1:0]  wr_addr,
	input  logic signed [WORD_W-1:0]        wr_data,
	input  logic                            rd_en,
	input  logic [$clog2(TABLE_DEPTH)-1:0]  rd_addr,
	output logic signed [WORD_W-1:0]        rd_data
);

	logic signed [WORD_W-1:0] mem [TABLE_DEPTH];
	logic signed [WORD_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: sv/sts_ctrl.sv
module sts_ctrl import sts_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	sts_in_if.sink                           query,
	sts_out_if.source                        result,
	input  logic [$clog2(TABLE_DEPTH):0]     used_len,
	output logic                             wr_en,
	output logic [$clog2(TABLE_DEPTH)-1:0]   wr_addr,
	output logic signed [WORD_W-1:0]         wr_data,
	output logic                             rd_en,
	output logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
	input  logic signed [WORD_W-1:0]         rd_data
);

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned LW = AW + 1;
	localparam int unsigned SW = AW + 2;
	localparam int unsigned XW = ((AW > IDX_W) ? AW : IDX_W) + 1;
	localparam logic signed [SW-1:0] ONE = SW'(1);

	state_t state_q, state_d;

	logic signed [WORD_W-1:0] key_q;
	logic signed [SW-1:0]     lo_q, hi_q, mid_q;
	logic signed [SW-1:0]     lo_d, hi_d, mid_d;
	logic signed [SW-1:0]     lo_n, hi_n, mid_n, hi_start;
	logic [AW-1:0]            idx_q, idx_d;
	logic                     hit_q, hit_d;
	logic [POS_W-1:0]         hit_pos_q, hit_pos_d;
	logic                     res_valid_q;
	logic                     res_found_q;
	logic [POS_W-1:0]         res_pos_q;
	logic                     accept;
	logic                     slot_free;
	logic [XW-1:0]            idx_ext;
	logic                     eq, lt, gt;

	assign accept    = query.valid && query.ready;
	assign slot_free = !res_valid_q || result.ready;
	assign idx_ext   = XW'(query.entry_index);

	assign eq = (key_q == rd_data);
	assign lt = (key_q < rd_data);
	assign gt = (key_q > rd_data);

	assign hi_start = $signed({1'b0, used_len}) - ONE;
	assign lo_n     = gt ? (mid_q + ONE) : lo_q;
	assign hi_n     = lt ? (mid_q - ONE) : hi_q;
	assign mid_n    = lo_n + ((hi_n - lo_n) >>> 1);

	assign wr_data = query.word_value;
	assign wr_addr = AW'(idx_ext);

	always_comb begin
		state_d     = state_q;
		query.ready = 1'b0;
		wr_en       = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = '0;
		lo_d        = lo_q;
		hi_d        = hi_q;
		mid_d       = mid_q;
		idx_d       = idx_q;
		hit_d       = hit_q;
		hit_pos_d   = hit_pos_q;
		unique case (state_q)
			ST_IDLE: begin
				query.ready = 1'b1;
				if (query.valid) begin
					case (mode_t'(query.mode))
						MODE_STORE: begin
							wr_en = (idx_ext < XW'(TABLE_DEPTH));
						end
						MODE_BINARY: begin
							lo_d      = '0;
							hi_d      = hi_start;
							mid_d     = hi_start >>> 1;
							hit_d     = 1'b0;
							hit_pos_d = '0;
							if (used_len == '0) begin
								state_d = ST_DONE;
							end else begin
								rd_en   = 1'b1;
								rd_addr = mid_d[AW-1:0];
								state_d = ST_BIN;
							end
						end
						MODE_LINEAR: begin
							idx_d     = '0;
							hit_d     = 1'b0;
							hit_pos_d = '0;
							if (used_len == '0) begin
								state_d = ST_DONE;
							end else begin
								rd_en   = 1'b1;
								rd_addr = '0;
								state_d = ST_LIN;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_BIN: begin
				if (eq) begin
					hit_d     = 1'b1;
					hit_pos_d = POS_W'(mid_q[AW-1:0]);
					state_d   = ST_DONE;
				end else if (lo_n > hi_n) begin
					state_d = ST_DONE;
				end else begin
					lo_d    = lo_n;
					hi_d    = hi_n;
					mid_d   = mid_n;
					rd_en   = 1'b1;
					rd_addr = mid_n[AW-1:0];
				end
			end
			ST_LIN: begin
				if (eq) begin
					hit_d     = 1'b1;
					hit_pos_d = POS_W'(idx_q);
					state_d   = ST_DONE;
				end else if (LW'(idx_q) + LW'(1) == used_len) begin
					state_d = ST_DONE;
				end else begin
					idx_d   = idx_q + AW'(1);
					rd_en   = 1'b1;
					rd_addr = idx_d;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && slot_free) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_q      <= lo_d;
		hi_q      <= hi_d;
		mid_q     <= mid_d;
		idx_q     <= idx_d;
		hit_q     <= hit_d;
		hit_pos_q <= hit_pos_d;
		if (accept) begin
			key_q <= query.word_value;
		end
		if (state_q == ST_DONE && slot_free) begin
			res_found_q <= hit_q;
			res_pos_q   <= hit_pos_q;
		end
	end

	assign result.valid    = res_valid_q;
	assign result.found    = res_found_q;
	assign result.position = res_pos_q;

`ifndef SYNTHESIS
	a_bin_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BIN) |-> (lo_q <= hi_q))
		else $error("binary search running with crossed bounds");
	a_lin_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LIN) |-> (LW'(idx_q) < used_len))
		else $error("linear scan beyond used length");
	a_rise_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside completion");
	a_store_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && query.mode == MODE_STORE) |=> (state_q == ST_IDLE))
		else $error("store transfer left idle");
	a_no_read_idle_store: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !rd_en)
		else $error("table written and read in one cycle");
`endif

endmodule

// File: sv/sorted_table_search.sv
// channel  | role | payload                                  | transfer
// ---------+------+------------------------------------------+--------------------
// query    | sink | mode, entry_index, word_value            | valid && ready
// result   | src  | found, position                          | valid && ready
// cfg      | in   | cfg_wdata = table_length                 | cfg_we
//
// A store is written to the table when it is accepted. A binary query holds the block for an
// accept step, P probes and a done step, P the number of probes (at most clog2(length) + 1,
// 11 for a full 1024-entry table), one probe per cycle through the table with its registered read.
// A linear query holds it for accept, N scanned entries (at most the length) and done steps.
// The result is offered from the cycle after the last of these.
// Reset clears control and the length register only; the table is not cleared.
// A stalled result holds in the output register; the next item is taken meanwhile.
module sorted_table_search import sts_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	sts_in_if.sink               query,
	sts_out_if.source            result,
	input  logic                 cfg_we,
	input  logic [CFG_LEN_W-1:0] cfg_wdata
);

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned LW = AW + 1;
	localparam int unsigned CW = (LW > CFG_LEN_W) ? LW : CFG_LEN_W;

	logic [CFG_LEN_W-1:0]     len_q;
	logic [CW-1:0]            len_ext;
	logic [LW-1:0]            used_len;
	logic                     wr_en, rd_en;
	logic [AW-1:0]            wr_addr, rd_addr;
	logic signed [WORD_W-1:0] wr_data, rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cfg_we) begin
			len_q <= cfg_wdata;
		end
	end

	assign len_ext  = CW'(len_q);
	assign used_len = (len_ext > CW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : LW'(len_ext);

	sts_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.query   (query),
		.result  (result),
		.used_len(used_len),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sts_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

endmodule
